/* rtl/fsnp_pkg.sv */
// ----------------------------------------------------------------------------
// fsnp_pkg: shared types and constants of the bounded format printer.
// Holds operation codes, character constants, parse modes, controller states
// and the command and status structures between controller and datapath.
// ----------------------------------------------------------------------------
package fsnp_pkg;

  // Default sizes.
  localparam int DIGIT_SLOTS_DEF = 22;
  localparam int COUNT_WIDTH_DEF = 24;

  // Fixed field widths.
  localparam int CAP_W = 16;
  localparam int TL_W  = 24;
  localparam int ARG_W = 64;
  localparam logic [TL_W-1:0] TL_MAX = 24'hFFFFFF;

  // Input operation codes.
  localparam logic [2:0] OP_FMT  = 3'd0;
  localparam logic [2:0] OP_ARG  = 3'd1;
  localparam logic [2:0] OP_STR  = 3'd2;
  localparam logic [2:0] OP_SEND = 3'd3;
  localparam logic [2:0] OP_FEND = 3'd4;

  // Conversion width codes.
  localparam logic [1:0] WC_16 = 2'd0;
  localparam logic [1:0] WC_32 = 2'd1;
  localparam logic [1:0] WC_64 = 2'd2;

  // Characters of the format language.
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    M_LIT, M_PCT, M_H, M_L, M_LL, M_ARG, M_STR
  } mode_t;

  typedef enum logic [1:0] {
    B_DEC, B_HEX, B_OCT, B_CHR
  } base_t;

  typedef struct packed {
    logic       sgn;
    logic [1:0] wc;
    base_t      base;
  } pend_t;

  // Where the character of one emit comes from.
  typedef enum logic [2:0] {
    CS_BYTE, CS_ARG, CS_H, CS_L, CS_PCT, CS_MINUS, CS_DIGIT, CS_TERM
  } char_src_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_QUEUE, S_PREP, S_DABBLE, S_SPLIT, S_DIGITS, S_TERM
  } state_t;

  typedef struct packed {
    logic      take;
    logic      emit;
    char_src_t src;
    logic      final_emit;
    logic      term_follows;
    logic      num_load;
    logic      dabble;
    logic      split;
    pend_t     pend;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_val;
    logic       arg_neg;
    logic       out_free;
    logic       dab_last;
    logic       split_last;
    logic       dig_last;
  } stat_t;

  // Lowercase hex digit character.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h57 + {4'h0, d});
  endfunction

endpackage

/* rtl/fsnp_ctrl.sv */
// ----------------------------------------------------------------------------
// fsnp_ctrl: format parser and sequencer.
// Tracks the parse mode and pending conversion, decodes each item into a short
// list of characters, and steps the datapath through digit generation.
// ----------------------------------------------------------------------------
module fsnp_ctrl import fsnp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t    state_r, state_nxt;
  mode_t     mode_r, mode_nxt;
  pend_t     pend_r, pend_nxt;
  char_src_t src_r [3];
  char_src_t src_nxt [3];
  logic [1:0] qn_r, qn_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic      num_r, num_nxt;
  logic      term_r, term_nxt;
  logic      queue_end;

  assign queue_end = (idx_r == (qn_r - 2'd1));

  // Decode of the latched item against the parse mode.
  always_comb begin
    logic [7:0] b;
    logic       conv;
    pend_t      cp;
    b    = stat.byte_val;
    conv = (b == CH_D) || (b == CH_I) || (b == CH_X) || (b == CH_O);
    cp.sgn  = (b == CH_D) || (b == CH_I);
    cp.wc   = WC_32;
    cp.base = (b == CH_X) ? B_HEX : ((b == CH_O) ? B_OCT : B_DEC);
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    src_nxt[0] = CS_BYTE;
    src_nxt[1] = CS_BYTE;
    src_nxt[2] = CS_BYTE;
    qn_nxt   = 2'd0;
    num_nxt  = 1'b0;
    term_nxt = 1'b0;
    if (state_r != S_DECODE) begin
      src_nxt  = src_r;
      qn_nxt   = qn_r;
      num_nxt  = num_r;
      term_nxt = term_r;
    end else begin
      case (stat.op)
        OP_FMT: begin
          case (mode_r)
            M_LIT: begin
              if (b == CH_PCT) mode_nxt = M_PCT;
              else begin
                src_nxt[0] = CS_BYTE;
                qn_nxt = 2'd1;
              end
            end
            M_PCT: begin
              mode_nxt = M_LIT;
              if (b == CH_C) begin
                pend_nxt = '{sgn: 1'b0, wc: WC_32, base: B_CHR};
                mode_nxt = M_ARG;
              end else if (b == CH_S) begin
                mode_nxt = M_STR;
              end else if (b == CH_PCT) begin
                src_nxt[0] = CS_PCT;
                qn_nxt = 2'd1;
              end else if (b == CH_H) begin
                mode_nxt = M_H;
              end else if (b == CH_L) begin
                mode_nxt = M_L;
              end else if (conv) begin
                pend_nxt = cp;
                mode_nxt = M_ARG;
              end
            end
            M_H, M_L, M_LL: begin
              if (mode_r == M_L && b == CH_L) begin
                mode_nxt = M_LL;
              end else if (conv) begin
                pend_nxt = cp;
                pend_nxt.wc = (mode_r == M_H) ? WC_16 : WC_64;
                mode_nxt = M_ARG;
              end else begin
                // Dangling modifier: print the letters, then the byte as a literal.
                mode_nxt = M_LIT;
                src_nxt[0] = (mode_r == M_H) ? CS_H : CS_L;
                qn_nxt = 2'd1;
                if (mode_r == M_LL) begin
                  src_nxt[1] = CS_L;
                  qn_nxt = 2'd2;
                end
                if (b == CH_PCT) mode_nxt = M_PCT;
                else begin
                  src_nxt[qn_nxt] = CS_BYTE;
                  qn_nxt = qn_nxt + 2'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        OP_ARG: begin
          if (mode_r == M_ARG) begin
            mode_nxt = M_LIT;
            if (pend_r.base == B_CHR) begin
              src_nxt[0] = CS_ARG;
              qn_nxt = 2'd1;
            end else begin
              num_nxt = 1'b1;
              if (stat.arg_neg) begin
                src_nxt[0] = CS_MINUS;
                qn_nxt = 2'd1;
              end
            end
          end
        end
        OP_STR: begin
          if (mode_r == M_STR) begin
            src_nxt[0] = CS_BYTE;
            qn_nxt = 2'd1;
          end
        end
        OP_SEND: begin
          if (mode_r == M_STR) mode_nxt = M_LIT;
        end
        OP_FEND: begin
          // Flush dangling modifiers, then write the terminator.
          if (mode_r == M_H) begin
            src_nxt[0] = CS_H;
            qn_nxt = 2'd1;
          end else if (mode_r == M_L) begin
            src_nxt[0] = CS_L;
            qn_nxt = 2'd1;
          end else if (mode_r == M_LL) begin
            src_nxt[0] = CS_L;
            src_nxt[1] = CS_L;
            qn_nxt = 2'd2;
          end
          term_nxt = 1'b1;
          mode_nxt = M_LIT;
          pend_nxt = '{sgn: 1'b0, wc: WC_16, base: B_DEC};
        end
        default: begin
        end
      endcase
    end
  end

  // Queue index.
  always_comb begin
    idx_nxt = idx_r;
    if (state_r == S_DECODE) idx_nxt = 2'd0;
    else if (state_r == S_QUEUE && stat.out_free) idx_nxt = idx_r + 2'd1;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (qn_nxt != 2'd0) state_nxt = S_QUEUE;
        else if (num_nxt)   state_nxt = S_PREP;
        else if (term_nxt)  state_nxt = S_TERM;
        else                state_nxt = S_IDLE;
      end
      S_QUEUE: begin
        if (stat.out_free && queue_end) begin
          if (num_r)       state_nxt = S_PREP;
          else if (term_r) state_nxt = S_TERM;
          else             state_nxt = S_IDLE;
        end
      end
      S_PREP:   state_nxt = (pend_r.base == B_DEC) ? S_DABBLE : S_SPLIT;
      S_DABBLE: if (stat.dab_last) state_nxt = S_SPLIT;
      S_SPLIT:  if (stat.split_last) state_nxt = S_DIGITS;
      S_DIGITS: if (stat.out_free && stat.dig_last) state_nxt = S_IDLE;
      S_TERM:   if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.pend = pend_r;
    cmd.src  = CS_BYTE;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: cmd.take = in_valid;
      S_QUEUE: begin
        cmd.emit         = stat.out_free;
        cmd.src          = src_r[idx_r];
        cmd.final_emit   = queue_end && !num_r && !term_r;
        cmd.term_follows = term_r;
      end
      S_PREP:   cmd.num_load = 1'b1;
      S_DABBLE: cmd.dabble = 1'b1;
      S_SPLIT:  cmd.split = 1'b1;
      S_DIGITS: begin
        cmd.emit       = stat.out_free;
        cmd.src        = CS_DIGIT;
        cmd.final_emit = stat.dig_last;
      end
      S_TERM: begin
        cmd.emit         = stat.out_free;
        cmd.src          = CS_TERM;
        cmd.final_emit   = 1'b1;
        cmd.term_follows = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_LIT;
      pend_r  <= '{sgn: 1'b0, wc: WC_16, base: B_DEC};
      qn_r    <= 2'd0;
      idx_r   <= 2'd0;
      num_r   <= 1'b0;
      term_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      qn_r    <= qn_nxt;
      idx_r   <= idx_nxt;
      num_r   <= num_nxt;
      term_r  <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
  end

  // An emit is only issued when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free) else $error("emit while output register busy");

  // Decoding always follows an accepted item.
  a_decode_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE) |-> $past(in_valid && !in_stall))
    else $error("decode without accepted item");

endmodule

/* rtl/fsnp_dp.sv */
// ----------------------------------------------------------------------------
// fsnp_dp: datapath of the bounded format printer.
// Holds the capacity register, the latched item, the binary-to-BCD converter,
// the digit buffer, the position and length counters and the output register.
// ----------------------------------------------------------------------------
module fsnp_dp import fsnp_pkg::*; #(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  input  logic [2:0]        in_operation,
  input  logic [7:0]        in_byte_value,
  input  logic [ARG_W-1:0]  in_arg_value,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_char,
  output logic [CAP_W-1:0]  out_position,
  output logic              out_is_terminator,
  output logic [TL_W-1:0]   out_total_length,
  output logic              out_last,
  input  cmd_t              cmd,
  output stat_t             stat
);

  localparam int SPLIT_W = DIGIT_SLOTS * 4;
  localparam int N_W     = $clog2(DIGIT_SLOTS + 1);
  localparam int IDX_W   = $clog2(DIGIT_SLOTS);
  localparam int DAB_W   = $clog2(ARG_W);

  logic [CAP_W-1:0]       cap_r;
  logic [2:0]             op_r;
  logic [7:0]             byte_r;
  logic [ARG_W-1:0]       arg_r;
  logic [ARG_W-1:0]       wv_r, wv_nxt;
  logic [SPLIT_W-1:0]     sr_r, sr_nxt;
  logic [DAB_W-1:0]       dab_r, dab_nxt;
  logic [N_W-1:0]         n_r, n_nxt;
  logic [3:0]             dig_r [DIGIT_SLOTS];
  logic [CAP_W-1:0]       wp_r, wp_nxt;
  logic [COUNT_WIDTH-1:0] ct_r, ct_nxt;
  logic                   ov_r, ov_nxt;
  logic [7:0]             och_r, och_nxt;
  logic [CAP_W-1:0]       opos_r, opos_nxt;
  logic                   oterm_r, oterm_nxt;
  logic [TL_W-1:0]        otl_r, otl_nxt;
  logic                   olast_r, olast_nxt;

  logic [ARG_W-1:0]       mask, nar, mag;
  logic                   sign_bit, neg;
  logic [SPLIT_W-1:0]     adj, sr_sh;
  logic [3:0]             split_digit;
  logic [IDX_W-1:0]       nm1;
  logic [CAP_W-1:0]       limit;
  logic [COUNT_WIDTH-1:0] ct_inc;
  logic [7:0]             ch;
  logic                   out_free;

  function automatic logic [TL_W-1:0] clip_tl(input logic [COUNT_WIDTH-1:0] c);
    logic [32:0] e;
    e = 33'(c);
    return (e > 33'(TL_MAX)) ? TL_MAX : e[TL_W-1:0];
  endfunction

  // Narrow the argument to the conversion width and take its magnitude.
  always_comb begin
    case (cmd.pend.wc)
      WC_16: begin
        mask = {{(ARG_W-16){1'b0}}, 16'hFFFF};
        sign_bit = arg_r[15];
      end
      WC_32: begin
        mask = {{(ARG_W-32){1'b0}}, 32'hFFFF_FFFF};
        sign_bit = arg_r[31];
      end
      default: begin
        mask = '1;
        sign_bit = arg_r[ARG_W-1];
      end
    endcase
    nar = arg_r & mask;
    neg = cmd.pend.sgn && sign_bit;
    mag = neg ? ((~nar + 64'd1) & mask) : nar;
  end

  // Add-three correction of every BCD digit before the shift.
  always_comb begin
    logic [3:0] d;
    adj = sr_r;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      d = sr_r[4*i +: 4];
      adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
    end
  end

  // One digit per cycle off the low end.
  assign split_digit = (cmd.pend.base == B_OCT) ? {1'b0, sr_r[2:0]} : sr_r[3:0];
  assign sr_sh       = (cmd.pend.base == B_OCT) ? (sr_r >> 3) : (sr_r >> 4);
  assign nm1         = IDX_W'(n_r - N_W'(1));

  // Digit generation datapath.
  always_comb begin
    wv_nxt  = wv_r;
    sr_nxt  = sr_r;
    dab_nxt = dab_r;
    n_nxt   = n_r;
    if (cmd.num_load) begin
      wv_nxt  = mag;
      sr_nxt  = (cmd.pend.base == B_DEC) ? '0 : {{(SPLIT_W-ARG_W){1'b0}}, mag};
      dab_nxt = '0;
      n_nxt   = '0;
    end else if (cmd.dabble) begin
      sr_nxt  = {adj[SPLIT_W-2:0], wv_r[ARG_W-1]};
      wv_nxt  = wv_r << 1;
      dab_nxt = dab_r + DAB_W'(1);
    end else if (cmd.split) begin
      sr_nxt = sr_sh;
      n_nxt  = n_r + N_W'(1);
    end else if (cmd.emit && cmd.src == CS_DIGIT) begin
      n_nxt = n_r - N_W'(1);
    end
  end

  // Character selection and limits.
  assign limit  = (cap_r == '0) ? '0 : (cap_r - 16'd1);
  assign ct_inc = (ct_r == '1) ? ct_r : (ct_r + COUNT_WIDTH'(1));

  always_comb begin
    case (cmd.src)
      CS_BYTE:  ch = byte_r;
      CS_ARG:   ch = arg_r[7:0];
      CS_H:     ch = CH_H;
      CS_L:     ch = CH_L;
      CS_PCT:   ch = CH_PCT;
      CS_MINUS: ch = CH_MINUS;
      CS_DIGIT: ch = digit_char(dig_r[nm1]);
      default:  ch = CH_NUL;
    endcase
  end

  assign out_free = !ov_r || !out_stall;

  // Counters and output register.
  always_comb begin
    wp_nxt    = wp_r;
    ct_nxt    = ct_r;
    ov_nxt    = ov_r && out_stall;
    och_nxt   = och_r;
    opos_nxt  = opos_r;
    oterm_nxt = oterm_r;
    otl_nxt   = otl_r;
    olast_nxt = olast_r;
    if (cmd.emit) begin
      if (cmd.src == CS_TERM) begin
        ov_nxt    = 1'b1;
        och_nxt   = CH_NUL;
        opos_nxt  = wp_r;
        oterm_nxt = 1'b1;
        otl_nxt   = clip_tl(ct_r);
        olast_nxt = 1'b1;
        wp_nxt    = '0;
        ct_nxt    = '0;
      end else begin
        ct_nxt = ct_inc;
        if (wp_r < limit) begin
          // Later characters all fall off the end once the buffer is full.
          ov_nxt    = 1'b1;
          och_nxt   = ch;
          opos_nxt  = wp_r;
          oterm_nxt = 1'b0;
          otl_nxt   = clip_tl(ct_inc);
          olast_nxt = cmd.final_emit ||
                      (!cmd.term_follows && ((wp_r + 16'd1) == limit));
          wp_nxt    = wp_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
      wp_r  <= '0;
      ct_r  <= '0;
      ov_r  <= 1'b0;
      wv_r  <= '0;
      dab_r <= '0;
      n_r   <= '0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      wp_r  <= wp_nxt;
      ct_r  <= ct_nxt;
      ov_r  <= ov_nxt;
      wv_r  <= wv_nxt;
      dab_r <= dab_nxt;
      n_r   <= n_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_operation;
      byte_r <= in_byte_value;
      arg_r  <= in_arg_value;
    end
    if (cmd.split) dig_r[n_r[IDX_W-1:0]] <= split_digit;
    sr_r    <= sr_nxt;
    och_r   <= och_nxt;
    opos_r  <= opos_nxt;
    oterm_r <= oterm_nxt;
    otl_r   <= otl_nxt;
    olast_r <= olast_nxt;
  end

  assign stat.op         = op_r;
  assign stat.byte_val   = byte_r;
  assign stat.arg_neg    = neg;
  assign stat.out_free   = out_free;
  assign stat.dab_last   = (dab_r == '1);
  assign stat.split_last = (sr_sh == '0) || (n_r == N_W'(DIGIT_SLOTS - 1));
  assign stat.dig_last   = (n_r == N_W'(1));

  assign out_valid         = ov_r;
  assign out_char          = och_r;
  assign out_position      = opos_r;
  assign out_is_terminator = oterm_r;
  assign out_total_length  = otl_r;
  assign out_last          = olast_r;

  // The terminator restarts position and length.
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.src == CS_TERM) |=> (wp_r == '0 && ct_r == '0))
    else $error("counters not cleared after terminator");

  // The digit count never runs past the buffer.
  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_W'(DIGIT_SLOTS)) else $error("digit count out of range");

endmodule

/* rtl/format_string_number_printer_unit.sv */
// ----------------------------------------------------------------------------
// format_string_number_printer_unit: bounded printf-subset formatter.
// Takes format bytes, arguments and string bytes one item at a time and
// produces the characters stored into the destination buffer.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item is accepted, then decoded, then
// each produced character is emitted in turn. Hex and octal arguments add
// a setup step, then the value is split into digits and the digits are
// printed. Decimal arguments first pass through a shift-and-add BCD
// converter. The output register lets the next item be taken while the
// last character still waits on out_stall; any character waits for the
// output register to free up.
module format_string_number_printer_unit import fsnp_pkg::*; #(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_operation,
  input  logic [7:0]       in_byte_value,
  input  logic [ARG_W-1:0] in_arg_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic [CAP_W-1:0] out_position,
  output logic             out_is_terminator,
  output logic [TL_W-1:0]  out_total_length,
  output logic             out_last
);

  cmd_t  cmd;
  stat_t stat;

  // Parser and sequencer.
  fsnp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Digit generation, counters and output register.
  fsnp_dp #(
    .DIGIT_SLOTS (DIGIT_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_operation      (in_operation),
    .in_byte_value     (in_byte_value),
    .in_arg_value      (in_arg_value),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_char          (out_char),
    .out_position      (out_position),
    .out_is_terminator (out_is_terminator),
    .out_total_length  (out_total_length),
    .out_last          (out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

/* tb/format_string_number_printer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// format_string_number_printer_unit_tb: self-checking bench of the formatter.
// A behavioral formatter predicts the stored characters of every item. The
// items run through directed format strings, then random well-formed formats
// mixed with noise, under several buffer capacities and idling patterns.
// ----------------------------------------------------------------------------
module format_string_number_printer_unit_tb;
  import fsnp_pkg::*;

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] pos;
    logic        term;
    logic [23:0] tl;
    logic        last;
  } char_rec_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_operation;
  logic [7:0]       in_byte_value;
  logic [ARG_W-1:0] in_arg_value;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_char;
  logic [CAP_W-1:0] out_position;
  logic             out_is_terminator;
  logic [TL_W-1:0]  out_total_length;
  logic             out_last;

  // Model state of the formatter.
  logic [15:0] capacity;
  mode_t       fmt_mode;
  logic        pend_sgn;
  logic [1:0]  pend_wc;
  base_t       pend_base;
  logic [15:0] write_pos;
  logic [23:0] char_count;

  char_rec_t expected_chars[$];
  char_rec_t step_chars[$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;

  format_string_number_printer_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_byte_value(in_byte_value),
    .in_arg_value(in_arg_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_char(out_char),
    .out_position(out_position), .out_is_terminator(out_is_terminator),
    .out_total_length(out_total_length), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Record one stored character of the current item.
  task automatic store_char(logic [7:0] ch, logic term);
    char_rec_t r;
    if (step_chars.size() < 23) begin
      r = '{ch: ch, pos: write_pos, term: term, tl: char_count, last: 1'b0};
      step_chars.push_back(r);
    end
  endtask

  // Count a character and store it while the buffer has room.
  task automatic put_char(logic [7:0] ch);
    logic [15:0] room;
    room = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
    if (char_count != 24'hFFFFFF) char_count++;
    if (write_pos < room) begin
      store_char(ch, 1'b0);
      write_pos++;
    end
  endtask

  task automatic literal_byte(logic [7:0] b);
    if (b == CH_PCT) fmt_mode = M_PCT;
    else put_char(b);
  endtask

  // Start a numeric conversion if the byte names one.
  function automatic bit start_numeric(logic [7:0] b, logic [1:0] wc);
    if (b == CH_D || b == CH_I) begin
      pend_sgn = 1'b1; pend_base = B_DEC;
    end else if (b == CH_X) begin
      pend_sgn = 1'b0; pend_base = B_HEX;
    end else if (b == CH_O) begin
      pend_sgn = 1'b0; pend_base = B_OCT;
    end else begin
      return 1'b0;
    end
    pend_wc = wc;
    fmt_mode = M_ARG;
    return 1'b1;
  endfunction

  task automatic format_char(logic [7:0] b);
    case (fmt_mode)
      M_LIT: literal_byte(b);
      M_PCT: begin
        fmt_mode = M_LIT;
        if (b == CH_C) begin
          pend_base = B_CHR; pend_sgn = 1'b0; pend_wc = WC_16; fmt_mode = M_ARG;
        end else if (b == CH_S) fmt_mode = M_STR;
        else if (b == CH_PCT) put_char(CH_PCT);
        else if (b == CH_H) fmt_mode = M_H;
        else if (b == CH_L) fmt_mode = M_L;
        else void'(start_numeric(b, WC_32));
      end
      M_H: if (!start_numeric(b, WC_16)) begin
        fmt_mode = M_LIT; put_char(CH_H); literal_byte(b);
      end
      M_L: begin
        if (b == CH_L) fmt_mode = M_LL;
        else if (!start_numeric(b, WC_64)) begin
          fmt_mode = M_LIT; put_char(CH_L); literal_byte(b);
        end
      end
      M_LL: if (!start_numeric(b, WC_64)) begin
        fmt_mode = M_LIT; put_char(CH_L); put_char(CH_L); literal_byte(b);
      end
      default: ;
    endcase
  endtask

  // Print an argument according to the pending conversion.
  task automatic print_arg(logic [63:0] v);
    logic [3:0]  digs[22];
    int          n;
    int          bits;
    logic [63:0] radix;
    logic [63:0] mask;
    n = 0;
    fmt_mode = M_LIT;
    if (pend_base == B_CHR) begin
      put_char(v[7:0]);
    end else begin
      bits = (pend_wc == WC_16) ? 16 : ((pend_wc == WC_32) ? 32 : 64);
      radix = (pend_base == B_HEX) ? 64'd16 : ((pend_base == B_OCT) ? 64'd8 : 64'd10);
      mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
      v &= mask;
      if (pend_sgn && v[bits-1]) begin
        put_char(CH_MINUS);
        v = (64'd0 - v) & mask;
      end
      do begin
        digs[n] = 4'(v % radix);
        v = v / radix;
        n++;
      end while (v != 0 && n < 22);
      while (n > 0) begin
        n--;
        put_char(digs[n] < 4'd10 ? 8'h30 + digs[n] : 8'h61 + digs[n] - 8'd10);
      end
    end
  endtask

  // Work out the stored characters that one accepted item causes.
  task automatic predict_item(logic [2:0] op, logic [7:0] b, logic [63:0] v);
    step_chars.delete();
    case (op)
      OP_FMT:  format_char(b);
      OP_ARG:  if (fmt_mode == M_ARG) print_arg(v);
      OP_STR:  if (fmt_mode == M_STR) put_char(b);
      OP_SEND: if (fmt_mode == M_STR) fmt_mode = M_LIT;
      OP_FEND: begin
        if (fmt_mode == M_H) put_char(CH_H);
        else if (fmt_mode == M_L) put_char(CH_L);
        else if (fmt_mode == M_LL) begin
          put_char(CH_L); put_char(CH_L);
        end
        store_char(CH_NUL, 1'b1);
        fmt_mode = M_LIT; pend_sgn = 1'b0; pend_wc = WC_16; pend_base = B_DEC;
        write_pos = '0; char_count = '0;
      end
      default: ;
    endcase
    if (step_chars.size() > 0) step_chars[step_chars.size()-1].last = 1'b1;
    foreach (step_chars[k]) expected_chars.push_back(step_chars[k]);
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every accepted character with the oldest expectation.
  always @(posedge clk) begin
    char_rec_t want;
    char_rec_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{ch: out_char, pos: out_position, term: out_is_terminator,
              tl: out_total_length, last: out_last};
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output char=%h pos=%0d", got.ch, got.pos);
      end else begin
        want = expected_chars.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected ch=%h pos=%0d term=%b tl=%0d last=%b, ",
                      "got ch=%h pos=%0d term=%b tl=%0d last=%b"},
                     want.ch, want.pos, want.term, want.tl, want.last,
                     got.ch, got.pos, got.term, got.tl, got.last);
        end
      end
    end
  end

  // Send one item and predict it once accepted.
  task automatic send_item(logic [2:0] op, logic [7:0] b, logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_byte_value <= b;
    in_arg_value <= v;
    do @(posedge clk); while (in_stall);
    predict_item(op, b, v);
  endtask

  task automatic send_fmt(logic [7:0] b);
    send_item(OP_FMT, b, {$urandom, $urandom});
  endtask

  task automatic send_arg(logic [63:0] v);
    send_item(OP_ARG, 8'($urandom_range(255)), v);
  endtask

  // Hold the sender until every expected character has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() > 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [15:0] c);
    wait_drained();
    repeat (200) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = c;
  endtask

  function automatic logic [63:0] pick_arg();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return {$urandom, 16'h0, 16'h8000};
      5: return {32'h0, 32'h8000_0000};
      6: return 64'($urandom_range(99));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Directed formats: extremes, every conversion and the odd cases.
  task automatic test_directed();
    send_fmt("a"); send_fmt(CH_PCT); send_fmt(CH_PCT);
    send_fmt(CH_PCT); send_fmt(CH_C); send_arg(64'h41);
    send_fmt(CH_PCT); send_fmt(CH_S);
    send_item(OP_STR, 8'h00, 64'd0); send_item(OP_STR, 8'hFF, 64'd0);
    send_item(OP_SEND, 8'd0, 64'd0);
    send_fmt(CH_PCT); send_fmt(CH_H); send_fmt(CH_D); send_arg(64'h8000);
    send_fmt(CH_PCT); send_fmt(CH_L); send_fmt(CH_L); send_fmt(CH_I);
    send_arg(64'h8000_0000_0000_0000);
    send_fmt(CH_PCT); send_fmt(CH_L); send_fmt(CH_O); send_arg('1);
    send_item(OP_FEND, 8'd0, 64'd0);
    send_fmt(CH_PCT); send_fmt(CH_X); send_arg(64'hFFFF_FFFF);
    send_fmt(CH_PCT); send_fmt("q");
    send_item(OP_ARG, 8'd0, 64'd5);
    send_item(3'd7, 8'hFF, '1);
    send_fmt(CH_PCT); send_fmt(CH_H); send_fmt("z");
    send_fmt(CH_PCT); send_fmt(CH_L); send_fmt(CH_L);
    send_item(OP_FEND, 8'd0, 64'd0);
  endtask

  // Random formats: mostly well-formed pieces, some noise.
  task automatic test_random(int items);
    int sent;
    int k;
    logic [7:0] conv;
    sent = 0;
    while (sent < items) begin
      conv = (($urandom_range(3) == 0) ? CH_I : (($urandom_range(2) == 0) ? CH_D :
             (($urandom_range(1) == 0) ? CH_X : CH_O)));
      case ($urandom_range(11))
        0, 1: begin send_fmt(8'($urandom_range(255))); sent++; end
        2: begin send_fmt(CH_PCT); send_fmt(CH_PCT); sent += 2; end
        3: begin
          send_fmt(CH_PCT); send_fmt(CH_C); send_arg({$urandom, $urandom}); sent += 3;
        end
        4: begin
          send_fmt(CH_PCT); send_fmt(CH_S);
          for (k = $urandom_range(4); k > 0; k--) begin
            send_item(OP_STR, 8'($urandom_range(255)), {$urandom, $urandom}); sent++;
          end
          send_item(OP_SEND, 8'($urandom_range(255)), 64'd0); sent += 3;
        end
        5, 6, 7: begin
          send_fmt(CH_PCT);
          case ($urandom_range(3))
            0: send_fmt(CH_H);
            1: ;
            2: send_fmt(CH_L);
            default: begin send_fmt(CH_L); send_fmt(CH_L); end
          endcase
          send_fmt(conv); send_arg(pick_arg()); sent += 4;
        end
        8: begin
          send_fmt(CH_PCT);
          if ($urandom_range(1)) send_fmt(CH_H); else send_fmt(CH_L);
          send_fmt(8'($urandom_range(255))); sent += 3;
        end
        9: begin
          send_item(3'($urandom_range(7)), 8'($urandom_range(255)), {$urandom, $urandom});
          sent++;
        end
        default: begin send_item(OP_FEND, 8'($urandom_range(255)), 64'd0); sent++; end
      endcase
    end
    send_item(OP_FEND, 8'd0, 64'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_operation = OP_FMT;
    in_byte_value = '0;
    in_arg_value = '0;
    out_stall = 1'b0;
    mismatches = 0;
    capacity = '0;
    fmt_mode = M_LIT;
    pend_sgn = 1'b0;
    pend_wc = WC_16;
    pend_base = B_DEC;
    write_pos = '0;
    char_count = '0;
    send_idle_pct = 13;
    recv_idle_pct = 66;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_capacity(16'hFFFF);
    test_directed();
    test_random(25);
    wait_drained();
    set_capacity(16'd0);
    test_random(20);
    send_idle_pct = 66;
    recv_idle_pct = 13;
    set_capacity(16'd1);
    test_random(20);
    set_capacity(16'd8);
    test_random(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(16'($urandom_range(65535)));
    test_random(20);
    set_capacity(16'd5);
    test_random(15);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
